// File: rtl/core/baudot_fsk_tone_encoder_assert.svh
// Assertion macros for the Baudot tone encoder.
// All checks run on clk_i and are switched off while rst_ni is low.
`ifndef BAUDOT_FSK_TONE_ENCODER_ASSERT_SVH
`define BAUDOT_FSK_TONE_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define BFSK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfsk: same-cycle check failed");

// Next-cycle implication.
`define BFSK_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfsk: next-cycle check failed");

`endif

// File: rtl/core/bfsk_pkg.sv
`default_nettype none

package bfsk_pkg;

  // Field and register widths
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned SAMPLE_W = 15;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned FRAME_W  = 7;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CODE_W   = 5;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Parameter defaults
  localparam int unsigned SINE_INDEX_BITS_DEF = 8;
  localparam int unsigned PHASE_BITS_DEF      = 32;

  // Register reset values
  localparam logic [STEP_W-1:0]  ZERO_STEP_RST = 31'd97391263;
  localparam logic [STEP_W-1:0]  ONE_STEP_RST  = 31'd389565053;
  localparam logic [BURST_W-1:0] BURST_RST     = 16'd441;

  // Letters that can be framed
  localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h5A;

  // Item kinds on the mode field
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Last bit of a frame (stop bit)
  localparam logic [POS_W-1:0] STOP_POS = 3'd6;

  localparam int unsigned AMPLITUDE = 15000;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_ZERO_STEP = 2'd0,
    REG_ONE_STEP  = 2'd1,
    REG_BURST     = 2'd2
  } reg_idx_e;

  // ITA2 letter code, A first
  function automatic logic [CODE_W-1:0] ita2_code(logic [CODE_W-1:0] idx);
    logic [CODE_W-1:0] code;
    unique case (idx)
      5'd0:    code = 5'h18;
      5'd1:    code = 5'h13;
      5'd2:    code = 5'h0E;
      5'd3:    code = 5'h12;
      5'd4:    code = 5'h10;
      5'd5:    code = 5'h16;
      5'd6:    code = 5'h0B;
      5'd7:    code = 5'h05;
      5'd8:    code = 5'h0C;
      5'd9:    code = 5'h1A;
      5'd10:   code = 5'h1E;
      5'd11:   code = 5'h09;
      5'd12:   code = 5'h07;
      5'd13:   code = 5'h06;
      5'd14:   code = 5'h03;
      5'd15:   code = 5'h0D;
      5'd16:   code = 5'h1D;
      5'd17:   code = 5'h0A;
      5'd18:   code = 5'h14;
      5'd19:   code = 5'h01;
      5'd20:   code = 5'h1C;
      5'd21:   code = 5'h0F;
      5'd22:   code = 5'h19;
      5'd23:   code = 5'h17;
      5'd24:   code = 5'h15;
      5'd25:   code = 5'h11;
      default: code = '0;
    endcase
    return code;
  endfunction

  // --- Sine table construction, elaboration time only ---

  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
  localparam int unsigned TAYLOR_TERMS = 40;

  // (2n)(2n+1) for the Taylor series of sin
  localparam logic [15:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    16'd0,    16'd6,    16'd20,   16'd42,   16'd72,   16'd110,  16'd156,  16'd210,
    16'd272,  16'd342,  16'd420,  16'd506,  16'd600,  16'd702,  16'd812,  16'd930,
    16'd1056, 16'd1190, 16'd1332, 16'd1482, 16'd1640, 16'd1806, 16'd1980, 16'd2162,
    16'd2352, 16'd2550, 16'd2756, 16'd2970, 16'd3192, 16'd3422, 16'd3660, 16'd3906,
    16'd4160, 16'd4422, 16'd4692, 16'd4970, 16'd5256, 16'd5550, 16'd5852, 16'd6162
  };

  // (a * b) >> 62, kept to 64 bits
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // a / d, truncated, by shift and subtract; d is never zero here
  function automatic logic [63:0] div_u64(logic [63:0] a, logic [15:0] d);
    logic [63:0] q;
    logic [16:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[15:0], a[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k of trunc(AMPLITUDE * sin(2*pi*k / 2^index_bits))
  function automatic logic [SAMPLE_W-1:0] sine_entry(int unsigned k, int unsigned index_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        sum;
    logic [63:0]        mag;
    logic [SAMPLE_W-1:0] m;
    int unsigned        half;
    int unsigned        quarter;
    int unsigned        kk;
    int unsigned        j;
    half    = 1 << (index_bits - 1);
    quarter = 1 << (index_bits - 2);
    kk      = k & (half - 1);
    j       = (kk <= quarter) ? kk : half - kk;
    if (j == 0) begin
      m = '0;
    end else if (j >= quarter) begin
      m = SAMPLE_W'(AMPLITUDE);
    end else begin
      x    = (PI_HALF_Q62 >> (index_bits - 2)) * 64'(j);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n < TAYLOR_TERMS; n++) begin
        if (term != '0) begin
          term = div_u64(mul_q62(term, x2), TAYLOR_DIV[n]);
          if ((n % 2) == 1) sum = sum - term;
          else              sum = sum + term;
        end
      end
      mag = mul_q62(sum, 64'(AMPLITUDE));
      if (mag > 64'(AMPLITUDE)) mag = 64'(AMPLITUDE);
      m = mag[SAMPLE_W-1:0];
    end
    return (k < half) ? m : (SAMPLE_W'(0) - m);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/baudot_fsk_tone_encoder.sv
// Channel   | Dir | Handshake               | Payload
// ----------+-----+-------------------------+---------------------------------------------
// in        | in  | in_valid_i / in_ready_o | mode_i, character_i
// out       | out | out_valid_o/out_ready_i | sample_o, sample_valid_o, last_of_char_o,
//           |     |                         | accepted_o, busy_res_o
// cfg (APB) | in  | psel/penable, pready=1  | paddr 0x0 zero step, 0x4 one step, 0x8 burst
//
// One item per clock while in_ready_o is high; the edge that takes an item also
// writes its result to the output register. The path is phase register -> sine ROM
// read -> result register, alongside the phase add and the burst count compare.
// Reset clears the frame state and the output valid flag and loads the default
// tone steps and burst length; no clearing pass.
// While the result register is full and not being taken, in_ready_o is low.
`default_nettype none

module baudot_fsk_tone_encoder #(
  parameter int unsigned SINE_INDEX_BITS = bfsk_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned PHASE_BITS      = bfsk_pkg::PHASE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  // item input
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               mode_i,
  input  wire logic [bfsk_pkg::CHAR_W-1:0]        character_i,

  // result output
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [bfsk_pkg::SAMPLE_W-1:0]    sample_o,
  output logic                                    sample_valid_o,
  output logic                                    last_of_char_o,
  output logic                                    accepted_o,
  output logic                                    busy_res_o,

  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bfsk_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [bfsk_pkg::DATA_W-1:0]        pwdata,
  output logic      [bfsk_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bfsk_pkg::STEP_W-1:0]  zero_step_q;
  logic [bfsk_pkg::STEP_W-1:0]  one_step_q;
  logic [bfsk_pkg::BURST_W-1:0] burst_q;
  logic                         cfg_wr;
  bfsk_pkg::reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = bfsk_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_step_q <= bfsk_pkg::ZERO_STEP_RST;
      one_step_q  <= bfsk_pkg::ONE_STEP_RST;
      burst_q     <= bfsk_pkg::BURST_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bfsk_pkg::REG_ZERO_STEP: zero_step_q <= pwdata[bfsk_pkg::STEP_W-1:0];
        bfsk_pkg::REG_ONE_STEP:  one_step_q  <= pwdata[bfsk_pkg::STEP_W-1:0];
        bfsk_pkg::REG_BURST:     burst_q     <= pwdata[bfsk_pkg::BURST_W-1:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bfsk_pkg::REG_ZERO_STEP: prdata = {1'b0, zero_step_q};
      bfsk_pkg::REG_ONE_STEP:  prdata = {1'b0, one_step_q};
      bfsk_pkg::REG_BURST:     prdata = {16'd0, burst_q};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_acc;

  // A waiting result does not block the next item if it is being taken now.
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [bfsk_pkg::FRAME_W-1:0] frame_q,   frame_d;
  logic [bfsk_pkg::POS_W-1:0]   bit_pos_q, bit_pos_d;
  logic [bfsk_pkg::BURST_W-1:0] cnt_q,     cnt_d;
  logic [PHASE_BITS-1:0]        phase_q,   phase_d;
  logic                         sending_q, sending_d;

  // Result fields for the item in hand
  logic signed [bfsk_pkg::SAMPLE_W-1:0] rom_sample;
  logic signed [bfsk_pkg::SAMPLE_W-1:0] smp_d;
  logic                                 valid_d;
  logic                                 last_d;
  logic                                 acc_d;

  logic [bfsk_pkg::FRAME_W:0]   frame_ext;
  logic                         cur_bit;
  logic [bfsk_pkg::STEP_W-1:0]  step_sel;
  logic [bfsk_pkg::BURST_W-1:0] burst_eff;
  logic [bfsk_pkg::BURST_W-1:0] cnt_inc;
  logic                         bit_end;
  logic                         is_letter;
  logic [bfsk_pkg::CHAR_W-1:0]  char_off;
  logic [bfsk_pkg::CODE_W-1:0]  code;

  bfsk_sine_rom #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_sine_rom (
    .idx_i    (phase_q[PHASE_BITS-1 -: SINE_INDEX_BITS]),
    .sample_o (rom_sample)
  );

  // Current bit and tone
  assign frame_ext = {1'b0, frame_q};
  assign cur_bit   = frame_ext[bit_pos_q];
  assign step_sel  = cur_bit ? one_step_q : zero_step_q;

  // A burst of zero behaves as one sample; a wrapped count also ends the bit.
  assign burst_eff = (burst_q == '0) ? bfsk_pkg::BURST_W'(1) : burst_q;
  assign cnt_inc   = cnt_q + bfsk_pkg::BURST_W'(1);
  assign bit_end   = (cnt_inc >= burst_eff) || (cnt_inc == '0);

  // Letter decode: start 0, code MSB first... i.e. code bit 4 goes out first
  assign is_letter = (character_i >= bfsk_pkg::CHAR_FIRST) &&
                     (character_i <= bfsk_pkg::CHAR_LAST);
  assign char_off  = character_i - bfsk_pkg::CHAR_FIRST;
  assign code      = bfsk_pkg::ita2_code(char_off[bfsk_pkg::CODE_W-1:0]);

  always_comb begin
    frame_d   = frame_q;
    bit_pos_d = bit_pos_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    sending_d = sending_q;
    smp_d     = '0;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    acc_d     = 1'b0;

    if (mode_i == bfsk_pkg::MODE_LOAD) begin
      // Load: refused while a frame is running or for a non-letter
      if (!sending_q && is_letter) begin
        frame_d   = {1'b1, code[0], code[1], code[2], code[3], code[4], 1'b0};
        bit_pos_d = '0;
        cnt_d     = '0;
        phase_d   = '0;
        sending_d = 1'b1;
        acc_d     = 1'b1;
      end
    end else if (sending_q) begin
      // Tick: emit the sample for the current phase, then advance
      smp_d   = rom_sample;
      valid_d = 1'b1;
      phase_d = phase_q + PHASE_BITS'(step_sel);
      cnt_d   = cnt_inc;
      if (bit_end) begin
        cnt_d   = '0;
        phase_d = '0;
        if (bit_pos_q >= bfsk_pkg::STOP_POS) begin
          last_d    = 1'b1;
          sending_d = 1'b0;
          bit_pos_d = '0;
        end else begin
          bit_pos_d = bit_pos_q + bfsk_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '0;
      bit_pos_q <= '0;
      cnt_q     <= '0;
      phase_q   <= '0;
      sending_q <= 1'b0;
    end else if (in_acc) begin
      frame_q   <= frame_d;
      bit_pos_q <= bit_pos_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      sending_q <= sending_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [bfsk_pkg::SAMPLE_W-1:0] sample_q;
  logic                                 sample_valid_q;
  logic                                 last_q;
  logic                                 accepted_q;
  logic                                 busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q       <= smp_d;
      sample_valid_q <= valid_d;
      last_q         <= last_d;
      accepted_q     <= acc_d;
      busy_q         <= sending_d;
    end
  end

  assign sample_o       = sample_q;
  assign sample_valid_o = sample_valid_q;
  assign last_of_char_o = last_q;
  assign accepted_o     = accepted_q;
  assign busy_res_o     = busy_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "baudot_fsk_tone_encoder_assert.svh"

  // a load taken mid-frame is refused and the frame carries on
  `BFSK_ASSERT_NXT(a_load_busy_refused,
                   in_acc && (mode_i == bfsk_pkg::MODE_LOAD) && sending_q,
                   out_valid_q && !accepted_q && sending_q)
  // a frame only ends on the flagged last sample
  `BFSK_ASSERT_IMP(a_end_flagged, $fell(sending_q), out_valid_q && last_q && sample_valid_q)
  // a result never both starts a frame and carries a sample
  `BFSK_ASSERT_IMP(a_excl_result, out_valid_q && sample_valid_q, !accepted_q)
  // sample stays within the table amplitude
  `BFSK_ASSERT_IMP(a_sample_range, out_valid_q && sample_valid_q,
                   (sample_q <= 15'sd15000) && (sample_q >= -15'sd15000))

endmodule

`default_nettype wire

// File: rtl/core/bfsk_sine_rom.sv
`default_nettype none

// Full-cycle sine lookup, table filled at elaboration.
module bfsk_sine_rom #(
  parameter int unsigned SINE_INDEX_BITS = bfsk_pkg::SINE_INDEX_BITS_DEF
) (
  input  wire logic        [SINE_INDEX_BITS-1:0]  idx_i,
  output logic signed      [bfsk_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int unsigned Depth = 1 << SINE_INDEX_BITS;

  logic [bfsk_pkg::SAMPLE_W-1:0] rom [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_rom
    localparam logic [bfsk_pkg::SAMPLE_W-1:0] Entry =
      bfsk_pkg::sine_entry(k, SINE_INDEX_BITS);
    assign rom[k] = Entry;
  end

  assign sample_o = $signed(rom[idx_i]);

endmodule

`default_nettype wire
